>>> hw/rtl/ibh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_pkg
// Shared widths, operation and status codes, and the request and result
// words passed between the top level and the heap core.
// ----------------------------------------------------------------------------
package ibh_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 10;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_RAISE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENCE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      count;
    } t_res;

endpackage
`default_nettype wire

>>> hw/rtl/indexed_binary_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_binary_heap
// Indexed min/max priority queue of item ids with push, pop and raise.
// ----------------------------------------------------------------------------
// One word is worked at a time. After reset the position table is cleared
// before the first word is taken. Push and raise sift up and pop sifts
// down, one level at a time: going up, a level takes a parent read, a key
// read and a compare and write; going down, it takes two child reads, two
// key reads and two compares. The single read port of each memory sets
// the per-level cost. A result sits in an output register while the next
// word is already accepted.
module indexed_binary_heap
    import ibh_pkg::*;
#(
    parameter int HEAP_CAPACITY = 1024,
    parameter int ID_COUNT      = 1024,
    parameter int KEY_BITS      = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire                       i_cfg_data,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire  [OP_W-1:0]           i_op,
    input  wire  [ID_W-1:0]           i_item_id,
    input  wire  signed [KEY_W-1:0]   i_item_key,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic [ID_W-1:0]           o_out_id,
    output logic signed [KEY_W-1:0]   o_out_key,
    output logic [STATUS_W-1:0]       o_status,
    output logic [COUNT_W-1:0]        o_count
);

    logic r_mode;
    logic r_out_valid;
    t_res r_out;
    logic core_ready;
    logic res_valid;
    logic res_take;
    t_req req;
    t_res res;

    assign req.op  = i_op;
    assign req.id  = i_item_id;
    assign req.key = i_item_key;

    ibh_core #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .ID_COUNT      (ID_COUNT),
        .KEY_BITS      (KEY_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_start     (i_in_valid && core_ready),
        .i_req       (req),
        .o_ready     (core_ready),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !core_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_id    = r_out.id;
    assign o_out_key   = r_out.key;
    assign o_status    = r_out.status;
    assign o_count     = r_out.count;

endmodule
`default_nettype wire

>>> hw/rtl/ibh_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_core
// Heap sequencer: slot, key and position memories walked one level at a time
// with a single shared key comparator.
// ----------------------------------------------------------------------------
module ibh_core
    import ibh_pkg::*;
#(
    parameter int HEAP_CAPACITY = 1024,
    parameter int ID_COUNT      = 1024,
    parameter int KEY_BITS      = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_mode,
    input  wire        i_start,
    input  t_req       i_req,
    output logic       o_ready,
    output logic       o_res_valid,
    input  wire        i_res_take,
    output t_res       o_res
);

    localparam int HA_W  = $clog2(HEAP_CAPACITY + 1);
    localparam int IDX_W = $clog2(ID_COUNT);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_DEC, S_POP2, S_POP3,
        S_SU_A, S_SU_B, S_SU_C,
        S_SD_A, S_SD_B, S_SD_C, S_SD_D, S_SD_E, S_DONE
    } t_state;

    t_state                     r_state;
    logic [OP_W-1:0]            r_op;
    logic [ID_W-1:0]            r_id;
    logic signed [KEY_BITS-1:0] r_key;
    logic [HA_W-1:0]            r_count;
    logic [HA_W-1:0]            r_x;
    logic [HA_W-1:0]            r_c;
    logic [ID_W-1:0]            r_cur_id;
    logic signed [KEY_BITS-1:0] r_cur_key;
    logic [ID_W-1:0]            r_c_id;
    logic signed [KEY_BITS-1:0] r_c_key;
    logic [ID_W-1:0]            r_d_id;
    logic [ID_W-1:0]            r_p_id;
    logic [ID_W-1:0]            r_res_id;
    logic signed [KEY_BITS-1:0] r_res_key;
    logic [STATUS_W-1:0]        r_res_status;
    logic [IDX_W-1:0]           r_clr;

    // memories
    logic [ID_W-1:0]            heap_mem [HEAP_CAPACITY + 1];
    logic signed [KEY_BITS-1:0] key_mem  [ID_COUNT];
    logic [HA_W-1:0]            slot_mem [ID_COUNT];

    logic [ID_W-1:0]            r_heap_rd;
    logic signed [KEY_BITS-1:0] r_key_rd;
    logic [HA_W-1:0]            r_slot_rd;

    logic [HA_W-1:0]            heap_ra;
    logic [IDX_W-1:0]           key_ra;
    logic                       heap_we;
    logic [HA_W-1:0]            heap_wa;
    logic [ID_W-1:0]            heap_wd;
    logic                       key_we;
    logic                       slot_we;
    logic [IDX_W-1:0]           slot_wa;
    logic [HA_W-1:0]            slot_wd;

    logic signed [KEY_BITS-1:0] cmp_a;
    logic signed [KEY_BITS-1:0] cmp_b;
    logic                       cmp_better;
    logic                       in_range;
    logic                       present;
    logic [HA_W:0]              child;
    logic                       push_go;
    logic                       raise_go;

    assign in_range   = int'(r_id) < ID_COUNT;
    assign present    = in_range && (r_slot_rd != '0);
    assign child      = {r_x, 1'b0};
    assign cmp_better = i_mode ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
    assign push_go    = (r_op == OP_PUSH) && in_range && !present
                        && (r_count < HA_W'(HEAP_CAPACITY));
    assign raise_go   = (r_op == OP_RAISE) && present;

    // shared comparator operands
    always_comb begin
        cmp_a = r_cur_key;
        cmp_b = r_key_rd;
        unique case (r_state)
            S_SD_D: begin
                cmp_a = r_key_rd;
                cmp_b = r_c_key;
            end
            S_SD_E: begin
                cmp_a = r_c_key;
                cmp_b = r_cur_key;
            end
            default: ;
        endcase
    end

    // memory port control
    always_comb begin
        heap_ra = HA_W'(1);
        key_ra  = IDX_W'(r_heap_rd);
        heap_we = 1'b0;
        heap_wa = r_x;
        heap_wd = r_cur_id;
        key_we  = 1'b0;
        slot_we = 1'b0;
        slot_wa = IDX_W'(r_cur_id);
        slot_wd = r_x;
        unique case (r_state)
            S_CLR: begin
                slot_we = 1'b1;
                slot_wa = r_clr;
                slot_wd = '0;
            end
            S_LOOK: key_ra = IDX_W'(r_id);
            S_DEC: begin
                heap_ra = r_count;
                key_we  = push_go || raise_go;
            end
            S_POP2: begin
                slot_we = 1'b1;
                slot_wa = IDX_W'(r_res_id);
                slot_wd = '0;
            end
            S_SU_A: begin
                heap_ra = r_x >> 1;
                if (r_x <= HA_W'(1)) begin
                    heap_we = 1'b1;
                    slot_we = 1'b1;
                end
            end
            S_SU_C: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (cmp_better) begin
                    heap_wd = r_p_id;
                    slot_wa = IDX_W'(r_p_id);
                end
            end
            S_SD_A: begin
                heap_ra = child[HA_W-1:0];
                if (child > {1'b0, r_count}) begin
                    heap_we = 1'b1;
                    slot_we = 1'b1;
                end
            end
            S_SD_B: heap_ra = HA_W'(r_c + HA_W'(1));
            S_SD_E: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (cmp_better) begin
                    heap_wd = r_c_id;
                    slot_wa = IDX_W'(r_c_id);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_heap_rd <= heap_mem[heap_ra];
        r_key_rd  <= key_mem[key_ra];
        r_slot_rd <= slot_mem[IDX_W'(r_id)];
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (key_we) begin
            key_mem[IDX_W'(r_id)] <= r_key;
        end
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(ID_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_req.op;
                        r_id    <= i_req.id;
                        r_key   <= KEY_BITS'(i_req.key);
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: r_state <= S_DEC;
                S_DEC: begin
                    r_res_id     <= r_id;
                    r_res_key    <= '0;
                    r_res_status <= ST_OK;
                    r_cur_id     <= r_id;
                    r_cur_key    <= r_key;
                    r_state      <= S_DONE;
                    if (r_op == OP_POP) begin
                        if (r_count == '0) begin
                            r_res_status <= ST_EMPTY;
                        end else begin
                            r_res_id <= r_heap_rd;
                            r_count  <= r_count - HA_W'(1);
                            r_state  <= S_POP2;
                        end
                    end else if (r_op == OP_PUSH) begin
                        if (!in_range) begin
                            r_res_status <= ST_PRESENCE;
                        end else if (present) begin
                            r_res_status <= ST_PRESENCE;
                            r_res_key    <= r_key_rd;
                        end else if (!push_go) begin
                            r_res_status <= ST_FULL;
                        end else begin
                            r_count   <= r_count + HA_W'(1);
                            r_x       <= r_count + HA_W'(1);
                            r_res_key <= r_key;
                            r_state   <= S_SU_A;
                        end
                    end else if (r_op == OP_RAISE) begin
                        if (!present) begin
                            r_res_status <= ST_PRESENCE;
                        end else begin
                            r_x       <= r_slot_rd;
                            r_res_key <= r_key;
                            r_state   <= S_SU_A;
                        end
                    end else if (present) begin
                        r_res_key <= r_key_rd;
                    end
                end
                S_POP2: begin
                    r_res_key <= r_key_rd;
                    r_cur_id  <= r_heap_rd;
                    r_state   <= (r_count == '0) ? S_DONE : S_POP3;
                end
                S_POP3: begin
                    r_cur_key <= r_key_rd;
                    r_x       <= HA_W'(1);
                    r_state   <= S_SD_A;
                end
                S_SU_A: r_state <= (r_x <= HA_W'(1)) ? S_DONE : S_SU_B;
                S_SU_B: begin
                    r_p_id  <= r_heap_rd;
                    r_state <= S_SU_C;
                end
                S_SU_C: begin
                    if (cmp_better) begin
                        r_x     <= r_x >> 1;
                        r_state <= S_SU_A;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SD_A: begin
                    r_c     <= child[HA_W-1:0];
                    r_state <= (child > {1'b0, r_count}) ? S_DONE : S_SD_B;
                end
                S_SD_B: begin
                    r_c_id  <= r_heap_rd;
                    r_state <= S_SD_C;
                end
                S_SD_C: begin
                    r_c_key <= r_key_rd;
                    r_d_id  <= r_heap_rd;
                    r_state <= (r_c < r_count) ? S_SD_D : S_SD_E;
                end
                S_SD_D: begin
                    if (cmp_better) begin
                        r_c     <= r_c + HA_W'(1);
                        r_c_id  <= r_d_id;
                        r_c_key <= r_key_rd;
                    end
                    r_state <= S_SD_E;
                end
                S_SD_E: begin
                    if (cmp_better) begin
                        r_x     <= r_c;
                        r_state <= S_SD_A;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.id     = r_res_id;
    assign o_res.key    = KEY_W'(r_res_key);
    assign o_res.status = r_res_status;
    assign o_res.count  = COUNT_W'(r_count);

    a_count_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HA_W'(HEAP_CAPACITY))
        else $error("heap count beyond capacity");

    a_empty_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_EMPTY) |-> r_count == '0)
        else $error("empty status with items held");

    a_sift_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SU_A || r_state == S_SD_A) |-> r_x != '0)
        else $error("sift at slot zero");

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("word taken while busy");

endmodule
`default_nettype wire

>>> tb/ibh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibh_checker
// Watches the config, request and result channels of the indexed heap, keeps
// its own copy of the heap and position tables, and compares every result
// word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module ibh_checker
    import ibh_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_valid,
    input  wire                     i_cfg_ready,
    input  wire                     i_cfg_data,
    input  wire                     i_in_valid,
    input  wire                     i_in_stall,
    input  wire  [OP_W-1:0]         i_op,
    input  wire  [ID_W-1:0]         i_item_id,
    input  wire  signed [KEY_W-1:0] i_item_key,
    input  wire                     i_out_valid,
    input  wire                     i_out_stall,
    input  wire  [ID_W-1:0]         i_out_id,
    input  wire  signed [KEY_W-1:0] i_out_key,
    input  wire  [STATUS_W-1:0]     i_status,
    input  wire  [COUNT_W-1:0]      i_count,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_seen
);

    localparam int CAP = 1024;

    logic [ID_W-1:0]         slot_id [1:CAP];
    logic signed [KEY_W-1:0] id_key  [0:1023];
    int                      id_slot [0:1023];
    int                      fill;
    logic                    max_first;
    t_res                    due_q [$];

    function automatic bit wins(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        return max_first ? (id_key[a] > id_key[b]) : (id_key[a] < id_key[b]);
    endfunction

    function automatic void put(logic [ID_W-1:0] id, int s);
        slot_id[s] = id;
        id_slot[id] = s;
    endfunction

    function automatic void bubble_up(logic [ID_W-1:0] id, int x);
        while (x > 1 && wins(id, slot_id[x/2])) begin
            put(slot_id[x/2], x);
            x = x / 2;
        end
        put(id, x);
    endfunction

    function automatic void bubble_down(logic [ID_W-1:0] id);
        int x;
        int c;
        x = 1;
        forever begin
            c = 2 * x;
            if (c > fill) break;
            if (c < fill && wins(slot_id[c+1], slot_id[c])) c++;
            if (!wins(slot_id[c], id)) break;
            put(slot_id[c], x);
            x = c;
        end
        put(id, x);
    endfunction

    function automatic t_res heap_apply(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                        logic signed [KEY_W-1:0] key);
        t_res r;
        logic [ID_W-1:0] top;
        bit present;
        present = id_slot[id] != 0;
        r = '{id: id, key: '0, status: ST_OK, count: '0};
        case (op)
            OP_POP: begin
                if (fill == 0) r.status = ST_EMPTY;
                else begin
                    top = slot_id[1];
                    r.id = top;
                    r.key = id_key[top];
                    id_slot[top] = 0;
                    fill--;
                    if (fill > 0) bubble_down(slot_id[fill+1]);
                end
            end
            OP_PUSH: begin
                if (present) begin
                    r.status = ST_PRESENCE;
                    r.key = id_key[id];
                end else if (fill >= CAP) r.status = ST_FULL;
                else begin
                    fill++;
                    id_key[id] = key;
                    bubble_up(id, fill);
                    r.key = key;
                end
            end
            OP_RAISE: begin
                if (!present) r.status = ST_PRESENCE;
                else begin
                    id_key[id] = key;
                    bubble_up(id, id_slot[id]);
                    r.key = key;
                end
            end
            default: if (present) r.key = id_key[id];
        endcase
        r.count = fill[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            fill      <= 0;
            max_first <= 1'b0;
            o_errors  <= 0;
            o_seen    <= 0;
            o_pending <= 0;
            foreach (id_slot[i]) id_slot[i] = 0;
            due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) max_first <= i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                o_seen <= o_seen + 1;
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected result word id %0d key %0d", $time,
                             i_out_id, i_out_key);
                    o_errors <= o_errors + 1;
                end else begin
                    want = due_q.pop_front();
                    if (want.id !== i_out_id || want.key !== i_out_key ||
                        want.status !== i_status || want.count !== i_count) begin
                        $display("%0t: mismatch exp id %0d key %0d st %0d cnt %0d",
                                 $time, want.id, want.key, want.status, want.count);
                        $display("%0t:          got id %0d key %0d st %0d cnt %0d",
                                 $time, i_out_id, i_out_key, i_status, i_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                due_q.push_back(heap_apply(i_op, i_item_id, i_item_key));
            o_pending <= due_q.size();
        end
    end

endmodule

>>> tb/tb_indexed_binary_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_binary_heap
// Drives directed then random push, pop and raise words through the indexed
// heap in both orders, with random gaps, a long result hold-off and a full
// heap, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_indexed_binary_heap;
    import ibh_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [OP_W-1:0]         op;
    logic [ID_W-1:0]         item_id;
    logic signed [KEY_W-1:0] item_key;
    logic                    out_valid;
    logic                    out_stall;
    logic [ID_W-1:0]         out_id;
    logic signed [KEY_W-1:0] out_key;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
    int                      errors;
    int                      pending;
    int                      seen;
    int                      cycles;
    int                      sent;
    bit                      hold_off;
    bit                      done;

    indexed_binary_heap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_item_id(item_id), .i_item_key(item_key),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_id(out_id), .o_out_key(out_key), .o_status(status), .o_count(count)
    );

    ibh_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_item_id(item_id), .i_item_key(item_key),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_id(out_id), .i_out_key(out_key), .i_status(status), .i_count(count),
        .o_errors(errors), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed(32'($urandom_range(0, 15)) - 8);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send(logic [OP_W-1:0] o, logic [ID_W-1:0] id,
                        logic signed [KEY_W-1:0] k);
        in_valid <= 1'b1;
        op       <= o;
        item_id  <= id;
        item_key <= k;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
        repeat (gap_len()) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_order(bit m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // pushes lead the mix and draw ids from 0..pool so pops and raises find work
    task automatic random_phase(int n, int pool);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40) send(OP_PUSH, 10'($urandom_range(0, pool)), rand_key());
            else if (r < 70) send(OP_POP, 10'($urandom()), rand_key());
            else if (r < 95) send(OP_RAISE, 10'($urandom_range(0, pool)), rand_key());
            else send(OP_SPARE, 10'($urandom()), rand_key());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else if (hold_off) out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 8) out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 99) < 40) out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000 && !done) begin
            $display("tb_indexed_binary_heap: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = 1'b0; in_valid = 1'b0;
        op = OP_PUSH; item_id = '0; item_key = '0;
        cycles = 0; sent = 0; hold_off = 1'b0; done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_order(1'b0);
        send(OP_POP, 10'd5, 32'sd1);
        send(OP_RAISE, 10'd7, 32'sd3);
        send(OP_PUSH, 10'd0, 32'sh7FFF_FFFF);
        send(OP_PUSH, 10'd1023, 32'sh8000_0000);
        send(OP_PUSH, 10'd9, 32'sd0);
        send(OP_PUSH, 10'd10, 32'sd0);
        send(OP_PUSH, 10'd9, 32'sd5);
        send(OP_RAISE, 10'd0, 32'sh8000_0000);
        send(OP_RAISE, 10'd10, 32'sd100);
        send(OP_SPARE, 10'd9, 32'sd0);
        send(OP_SPARE, 10'd500, 32'sd0);
        repeat (5) send(OP_POP, 10'h2AA, 32'sd0);
        drain();
        set_order(1'b1);
        send(OP_PUSH, 10'd3, -32'sd4);
        send(OP_PUSH, 10'd4, 32'sd4);
        send(OP_PUSH, 10'd5, 32'sd4);
        send(OP_RAISE, 10'd3, 32'sd9);
        repeat (4) send(OP_POP, 10'h155, 32'sd0);
        random_phase(150, 63);
        drain();
        set_order(1'b0);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                random_phase(150, 31);
                in_valid <= 1'b0;
            end
        join
        drain();
        // fill to capacity, then pop deep sifts out of the full heap
        for (int i = 0; i < 1024; i++) send(OP_PUSH, 10'(i), rand_key());
        send(OP_PUSH, 10'd77, 32'sd1);
        for (int i = 0; i < 100; i++) send(OP_RAISE, 10'($urandom()), rand_key());
        drain();
        set_order(1'b1);
        repeat (200) send(OP_POP, 10'($urandom()), rand_key());
        drain();
        random_phase(50, 1023);
        drain();
        done = 1'b1;
        $display("covered %0d words sent, %0d results, both orders, full and empty heap",
                 sent, seen);
        if (errors == 0)
            $display("tb_indexed_binary_heap: PASS");
        else
            $display("tb_indexed_binary_heap: FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ibh_pkg.sv
hw/rtl/ibh_core.sv
hw/rtl/indexed_binary_heap.sv
tb/ibh_checker.sv
tb/tb_indexed_binary_heap.sv
